// ===== hw/rtl/adsr_pkg.sv =====
`default_nettype none

package adsr_pkg;

    localparam int unsigned ENV_ENTRIES_DEF = 16;

    localparam int unsigned LEVEL_W    = 16;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned FINE_W     = LEVEL_W + FRAC_W;
    localparam int unsigned ENTRY_W    = 2 * LEVEL_W;
    localparam int unsigned PHASE_W    = 3;
    localparam int unsigned ACTION_W   = 2;
    localparam int unsigned INDEX_W    = 4;
    localparam int unsigned SUSTAIN_W  = 15;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // pending request bits
    localparam int unsigned REQ_W       = 3;
    localparam int unsigned REQ_HANG    = 0;
    localparam int unsigned REQ_DECAY   = 1;
    localparam int unsigned REQ_RELEASE = 2;

    // serial divider: quotient bits retired per cycle
    localparam int unsigned DIV_STEPS  = 2;
    localparam int unsigned DIV_CYCLES = FINE_W / DIV_STEPS;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

    // sustain hold count is sustain_level / 16
    localparam int unsigned HOLD_SHIFT = 4;

    localparam logic signed [LEVEL_W-1:0] RELEASE_FLOOR = LEVEL_W'(100);

    // delay words that act as commands
    localparam logic signed [LEVEL_W-1:0] DLY_OFF     = LEVEL_W'(0);
    localparam logic signed [LEVEL_W-1:0] DLY_HANG    = LEVEL_W'(-1);
    localparam logic signed [LEVEL_W-1:0] DLY_JUMP    = LEVEL_W'(-2);
    localparam logic signed [LEVEL_W-1:0] DLY_RESTART = LEVEL_W'(-3);

    typedef enum logic [3:0] {
        PH_OFF     = 4'd0,
        PH_INITIAL = 4'd1,
        PH_START   = 4'd2,
        PH_LOOP    = 4'd3,
        PH_FADE    = 4'd4,
        PH_HANG    = 4'd5,
        PH_DECAY   = 4'd6,
        PH_RELEASE = 4'd7,
        PH_SUSTAIN = 4'd8
    } t_phase;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_START = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_LEVEL = 2'd0,
        CFG_SUSTAIN_LEVEL = 2'd1,
        CFG_RELEASE_STEP  = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_ENTRY,
        S_DIV,
        S_FADE,
        S_POST,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wr_entry;
        logic start_env;
        logic take_req;
        logic exec;
        logic entry;
        logic div_fin;
        logic fade;
        logic post;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_phase phase;
        logic   hang_pend;
        logic   ent_div;
        logic   div_jump;
        logic   div_done;
    } t_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/adsr_in_if.sv =====
`default_nettype none

interface adsr_in_if;
    import adsr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [INDEX_W-1:0]         entry_index;
    logic signed [LEVEL_W-1:0]  entry_delay;
    logic signed [LEVEL_W-1:0]  entry_arg;
    logic                       req_hang;
    logic                       req_decay;
    logic                       req_release;

    modport source (
        output valid, action, entry_index, entry_delay, entry_arg,
               req_hang, req_decay, req_release,
        input  ready
    );

    modport sink (
        input  valid, action, entry_index, entry_delay, entry_arg,
               req_hang, req_decay, req_release,
        output ready
    );

endinterface

`default_nettype wire

// ===== hw/rtl/adsr_out_if.sv =====
`default_nettype none

interface adsr_out_if;
    import adsr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [LEVEL_W-1:0]  level;
    logic [PHASE_W-1:0]         phase;
    logic                       in_sustain;
    logic                       is_off;

    modport source (
        output valid, level, phase, in_sustain, is_off,
        input  ready
    );

    modport sink (
        input  valid, level, phase, in_sustain, is_off,
        output ready
    );

endinterface

`default_nettype wire

// ===== hw/rtl/adsr_div.sv =====
`default_nettype none

// Signed 32 / 16 divider, truncating toward zero, two quotient bits a cycle.
// Remainder is the magnitude remainder (valid as is for a positive dividend).
module adsr_div (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [adsr_pkg::FINE_W-1:0]     i_dividend,
    input  logic signed [adsr_pkg::LEVEL_W-1:0]    i_divisor,
    output logic                                   o_done,
    output logic signed [adsr_pkg::FINE_W-1:0]     o_quot,
    output logic [adsr_pkg::LEVEL_W-1:0]           o_rem
);
    import adsr_pkg::*;

    logic [FINE_W-1:0]    r_q;
    logic [FINE_W-1:0]    n_q;
    logic [LEVEL_W-1:0]   r_rem;
    logic [LEVEL_W-1:0]   n_rem;
    logic [LEVEL_W-1:0]   r_dvs;
    logic                 r_neg;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [LEVEL_W:0]     part;
    logic [LEVEL_W:0]     trial;

    // remainder stays below the divisor magnitude, so the shifted partial
    // fits LEVEL_W bits and the borrow of trial is exact
    always_comb begin
        n_q   = r_q;
        n_rem = r_rem;
        part  = '0;
        trial = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            part  = {n_rem, n_q[FINE_W-1]};
            trial = part - {1'b0, r_dvs};
            n_q   = {n_q[FINE_W-2:0], ~trial[LEVEL_W]};
            n_rem = trial[LEVEL_W] ? part[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend[FINE_W-1] ? -i_dividend : i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor[LEVEL_W-1] ? -i_divisor : i_divisor;
            r_neg <= i_dividend[FINE_W-1] ^ i_divisor[LEVEL_W-1];
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== hw/rtl/adsr_dpath.sv =====
`default_nettype none

module adsr_dpath #(
    parameter int unsigned ENV_ENTRIES = adsr_pkg::ENV_ENTRIES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  adsr_pkg::t_cmd                        i_cmd,
    output adsr_pkg::t_stat                       o_stat,
    input  logic [adsr_pkg::INDEX_W-1:0]          i_entry_index,
    input  logic signed [adsr_pkg::LEVEL_W-1:0]   i_entry_delay,
    input  logic signed [adsr_pkg::LEVEL_W-1:0]   i_entry_arg,
    input  logic                                  i_req_hang,
    input  logic                                  i_req_decay,
    input  logic                                  i_req_release,
    input  logic                                  i_cfg_we,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic signed [adsr_pkg::LEVEL_W-1:0]   o_level,
    output logic [adsr_pkg::PHASE_W-1:0]          o_phase,
    output logic                                  o_in_sustain,
    output logic                                  o_is_off
);
    import adsr_pkg::*;

    localparam int unsigned PTR_W = $clog2(ENV_ENTRIES);

    // configuration
    logic signed [LEVEL_W-1:0] r_init_level;
    logic [SUSTAIN_W-1:0]      r_sustain;
    logic signed [LEVEL_W-1:0] r_rel_step;

    // envelope table, read data registered
    logic [ENTRY_W-1:0]        r_table [ENV_ENTRIES];
    logic [ENTRY_W-1:0]        r_rd;

    // envelope state
    t_phase                    r_phase,   n_phase;
    logic [REQ_W-1:0]          r_pend,    n_pend;
    logic [PTR_W-1:0]          r_ptr,     n_ptr;
    logic signed [LEVEL_W-1:0] r_tick,    n_tick;
    logic signed [LEVEL_W-1:0] r_level,   n_level;
    logic [FINE_W-1:0]         r_fine,    n_fine;
    logic [FINE_W-1:0]         r_slope,   n_slope;
    logic                      r_div_jump, n_div_jump;

    // result word
    logic signed [LEVEL_W-1:0] r_out_level;
    logic [PHASE_W-1:0]        r_out_phase;
    logic                      r_out_sus;
    logic                      r_out_off;

    logic signed [LEVEL_W-1:0] rd_delay;
    logic signed [LEVEL_W-1:0] rd_arg;
    logic signed [LEVEL_W-1:0] dec_lv;
    logic signed [LEVEL_W-1:0] tick_m1;
    logic signed [LEVEL_W-1:0] sus_lvl;
    logic [FINE_W-1:0]         fine_sum;
    logic [PTR_W-1:0]          ptr_inc;
    logic                      is_jump;
    logic                      ent_div;
    logic                      idx_ok;

    logic                      div_start;
    logic                      div_done;
    logic signed [FINE_W-1:0]  div_dividend;
    logic signed [LEVEL_W-1:0] div_divisor;
    logic signed [FINE_W-1:0]  div_quot;
    logic [LEVEL_W-1:0]        div_rem;

    assign rd_delay = r_rd[ENTRY_W-1:LEVEL_W];
    assign rd_arg   = r_rd[LEVEL_W-1:0];
    assign dec_lv   = r_level - r_rel_step;
    assign tick_m1  = r_tick - LEVEL_W'(1);
    assign sus_lvl  = $signed({1'b0, r_sustain});
    assign fine_sum = r_fine + r_slope;
    assign ptr_inc  = (r_ptr == PTR_W'(ENV_ENTRIES - 1)) ? '0 : r_ptr + 1'b1;
    assign idx_ok   = 32'(i_entry_index) < 32'(ENV_ENTRIES);

    assign is_jump  = (rd_delay == DLY_JUMP);
    assign ent_div  = !(rd_delay == DLY_OFF || rd_delay == DLY_HANG ||
                        rd_delay == DLY_RESTART);

    // jump target is arg mod depth; a ramp slope is (arg - level) << 16 / delay
    assign div_start    = i_cmd.entry && ent_div;
    assign div_dividend = is_jump
        ? $signed({{(FINE_W - LEVEL_W){1'b0}}, rd_arg})
        : $signed({LEVEL_W'(rd_arg - r_level), {FRAC_W{1'b0}}});
    assign div_divisor  = is_jump ? LEVEL_W'(ENV_ENTRIES) : rd_delay;

    adsr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_level <= '0;
            r_sustain    <= '0;
            r_rel_step   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_INITIAL_LEVEL: r_init_level <= i_cfg_data;
                CFG_SUSTAIN_LEVEL: r_sustain    <= i_cfg_data[SUSTAIN_W-1:0];
                CFG_RELEASE_STEP:  r_rel_step   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry && idx_ok) begin
            r_table[PTR_W'(i_entry_index)] <= {i_entry_delay, i_entry_arg};
        end
        r_rd <= r_table[r_ptr];
    end

    always_comb begin
        n_phase    = r_phase;
        n_pend     = r_pend;
        n_ptr      = r_ptr;
        n_tick     = r_tick;
        n_level    = r_level;
        n_fine     = r_fine;
        n_slope    = r_slope;
        n_div_jump = r_div_jump;

        if (i_cmd.take_req) begin
            n_pend = r_pend | {i_req_release, i_req_decay, i_req_hang};
        end

        if (i_cmd.start_env) begin
            n_phase = PH_INITIAL;
            n_pend  = '0;
            n_tick  = '0;
            n_slope = '0;
        end

        if (i_cmd.exec) begin
            case (r_phase)
                PH_INITIAL: begin
                    n_level = r_init_level;
                    if (r_pend[REQ_HANG]) begin
                        n_phase = PH_HANG;
                    end else begin
                        n_ptr   = '0;
                        n_fine  = {r_init_level, {FRAC_W{1'b0}}};
                        n_phase = PH_LOOP;
                    end
                end
                PH_START: begin
                    n_ptr   = '0;
                    n_fine  = {r_level, {FRAC_W{1'b0}}};
                    n_phase = PH_LOOP;
                end
                PH_DECAY, PH_RELEASE: begin
                    if (r_sustain != '0 && r_phase == PH_DECAY) begin
                        if (dec_lv < sus_lvl) begin
                            n_level = sus_lvl;
                            n_tick  = LEVEL_W'(r_sustain >> HOLD_SHIFT);
                            n_phase = PH_SUSTAIN;
                        end else begin
                            n_level = dec_lv;
                        end
                    end else if (dec_lv < RELEASE_FLOOR) begin
                        n_level = '0;
                        n_phase = PH_OFF;
                    end else begin
                        n_level = dec_lv;
                    end
                end
                PH_SUSTAIN: begin
                    n_tick = tick_m1;
                    if (tick_m1 == '0) begin
                        n_phase = PH_RELEASE;
                    end
                end
                default: ;
            endcase
        end

        if (i_cmd.entry) begin
            n_tick     = rd_delay;
            n_div_jump = is_jump;
            if (rd_delay == DLY_OFF) begin
                n_phase = PH_OFF;
            end else if (rd_delay == DLY_HANG) begin
                n_phase = PH_HANG;
            end else if (rd_delay == DLY_RESTART) begin
                n_phase = PH_INITIAL;
            end
        end

        if (i_cmd.div_fin) begin
            if (r_div_jump) begin
                n_ptr = div_rem[PTR_W-1:0];
            end else begin
                n_slope = div_quot;
                n_phase = PH_FADE;
                n_ptr   = ptr_inc;
            end
        end

        if (i_cmd.fade) begin
            n_fine  = fine_sum;
            n_level = fine_sum[FINE_W-1:FRAC_W];
            n_tick  = tick_m1;
            if (tick_m1[LEVEL_W-1] || tick_m1 == '0) begin
                n_phase = PH_LOOP;
            end
        end

        // release wins over decay and drops both requests
        if (i_cmd.post) begin
            if (r_pend[REQ_RELEASE]) begin
                n_phase                = PH_RELEASE;
                n_pend[REQ_RELEASE]    = 1'b0;
                n_pend[REQ_DECAY]      = 1'b0;
            end else if (r_pend[REQ_DECAY]) begin
                n_phase                = PH_DECAY;
                n_pend[REQ_DECAY]      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_OFF;
            r_pend     <= '0;
            r_ptr      <= '0;
            r_tick     <= '0;
            r_level    <= '0;
            r_fine     <= '0;
            r_slope    <= '0;
            r_div_jump <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_pend     <= n_pend;
            r_ptr      <= n_ptr;
            r_tick     <= n_tick;
            r_level    <= n_level;
            r_fine     <= n_fine;
            r_slope    <= n_slope;
            r_div_jump <= n_div_jump;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_level <= r_level;
            r_out_phase <= (r_phase == PH_SUSTAIN) ? PHASE_W'(PH_RELEASE)
                                                   : PHASE_W'(r_phase);
            r_out_sus   <= (r_phase == PH_SUSTAIN);
            r_out_off   <= (r_phase == PH_OFF);
        end
    end

    always_comb begin
        o_stat.phase     = r_phase;
        o_stat.hang_pend = r_pend[REQ_HANG];
        o_stat.ent_div   = ent_div;
        o_stat.div_jump  = r_div_jump;
        o_stat.div_done  = div_done;
    end

    assign o_level      = r_out_level;
    assign o_phase      = r_out_phase;
    assign o_in_sustain = r_out_sus;
    assign o_is_off     = r_out_off;

endmodule

`default_nettype wire

// ===== hw/rtl/adsr_ctrl.sv =====
`default_nettype none

module adsr_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [adsr_pkg::ACTION_W-1:0]  i_action,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output adsr_pkg::t_cmd                 o_cmd,
    input  adsr_pkg::t_stat                i_stat
);
    import adsr_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (t_action'(i_action))
                        ACT_TICK: begin
                            o_cmd.take_req = 1'b1;
                            n_state        = S_EXEC;
                        end
                        ACT_WRITE: begin
                            o_cmd.wr_entry = 1'b1;
                            n_state        = S_DONE;
                        end
                        ACT_START: begin
                            o_cmd.start_env = 1'b1;
                            n_state         = S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                // a disabled envelope skips the request handling too
                if (i_stat.phase == PH_OFF) begin
                    n_state = S_DONE;
                end else if (i_stat.phase == PH_INITIAL && i_stat.hang_pend) begin
                    n_state = S_POST;
                end else if (i_stat.phase inside {PH_INITIAL, PH_START, PH_LOOP}) begin
                    n_state = S_LOAD;
                end else if (i_stat.phase == PH_FADE) begin
                    n_state = S_FADE;
                end else begin
                    n_state = S_POST;
                end
            end
            S_LOAD: begin
                n_state = S_ENTRY;
            end
            S_ENTRY: begin
                o_cmd.entry = 1'b1;
                n_state     = i_stat.ent_div ? S_DIV : S_POST;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.div_fin = 1'b1;
                    n_state       = i_stat.div_jump ? S_POST : S_FADE;
                end
            end
            S_FADE: begin
                o_cmd.fade = 1'b1;
                n_state    = S_POST;
            end
            S_POST: begin
                o_cmd.post = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/adsr_envelope_sequencer.sv =====
// Write, start, no-op and disabled-tick words go straight to the result register;
// other ticks add request handling, preceded by a ramp step (fade) or, for a new table
// entry, by load, decode and, for a ramp or jump, the serial divider (2 bits/cycle).
// One word in flight; the next word is taken the cycle after its result is
// registered, while that result may still wait on the output.
// Reset (synchronous, active low): envelope off, level and counters zero.
`default_nettype none

module adsr_envelope_sequencer #(
    parameter int unsigned ENV_ENTRIES = adsr_pkg::ENV_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    adsr_in_if.sink                           i_in,
    adsr_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import adsr_pkg::*;

    t_cmd  s_cmd;
    t_stat s_stat;

    adsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_action    (i_in.action),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (s_cmd),
        .i_stat      (s_stat)
    );

    adsr_dpath #(
        .ENV_ENTRIES (ENV_ENTRIES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (s_cmd),
        .o_stat        (s_stat),
        .i_entry_index (i_in.entry_index),
        .i_entry_delay (i_in.entry_delay),
        .i_entry_arg   (i_in.entry_arg),
        .i_req_hang    (i_in.req_hang),
        .i_req_decay   (i_in.req_decay),
        .i_req_release (i_in.req_release),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_level       (o_out.level),
        .o_phase       (o_out.phase),
        .o_in_sustain  (o_out.in_sustain),
        .o_is_off      (o_out.is_off)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input still ready right after a word was taken");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.load_out |-> !o_out.valid || o_out.ready)
        else $error("result register loaded over a pending word");

    a_fade_in_fade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.fade |-> s_stat.phase == PH_FADE)
        else $error("ramp step issued outside the fade phase");

    a_off_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.is_off |-> o_out.phase == PHASE_W'(PH_OFF) && !o_out.in_sustain)
        else $error("disabled result carries a live phase");

endmodule

`default_nettype wire

// ===== test/adsr_envelope_sequencer_tb.sv =====
module adsr_envelope_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import adsr_pkg::*;

    localparam int unsigned HOLD_OFF_CYCLES = 200;
    localparam int unsigned DRAIN_CYCLES    = 40;
    localparam int unsigned TABLE_DEPTH     = ENV_ENTRIES_DEF;

    typedef struct packed {
        t_action                   action;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [LEVEL_W-1:0] entry_delay;
        logic signed [LEVEL_W-1:0] entry_arg;
        logic                      req_hang;
        logic                      req_decay;
        logic                      req_release;
    } t_env_word;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic [PHASE_W-1:0]        phase;
        logic                      in_sustain;
        logic                      is_off;
    } t_env_result;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    t_cfg_reg cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    adsr_in_if  word_in ();
    adsr_out_if word_out ();

    adsr_envelope_sequencer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (word_in),
        .o_out      (word_out),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // envelope state as the block should hold it
    logic [ENTRY_W-1:0]        env_tab [TABLE_DEPTH];
    t_phase                    env_phase  = PH_OFF;
    logic [REQ_W-1:0]          env_pend   = '0;
    logic [INDEX_W-1:0]        env_ptr    = '0;
    logic signed [LEVEL_W-1:0] env_ticks  = '0;
    logic signed [LEVEL_W-1:0] env_level  = '0;
    logic signed [LEVEL_W-1:0] env_target = '0;
    logic [FINE_W-1:0]         env_fine   = '0;
    logic [FINE_W-1:0]         env_slope  = '0;

    logic signed [LEVEL_W-1:0] cfg_init    = '0;
    logic [SUSTAIN_W-1:0]      cfg_sustain = '0;
    logic signed [LEVEL_W-1:0] cfg_rstep   = '0;

    t_env_result levels_due [$];
    int unsigned mismatches = 0;
    int unsigned run_words  = 0;
    bit          tx_calm    = 1'b0;
    bit          hold_off_req = 1'b0;

    // fetch the entry under the pointer; a ramp entry also sets the slope
    function automatic void open_entry();
        logic [ENTRY_W-1:0]        e;
        logic signed [LEVEL_W-1:0] d;
        logic signed [FINE_W-1:0]  diff;
        longint                    q;
        e = env_tab[env_ptr];
        d = e[ENTRY_W-1:LEVEL_W];
        env_ticks = d;
        if (d == DLY_OFF) begin
            env_phase = PH_OFF;
        end else if (d == DLY_HANG) begin
            env_phase = PH_HANG;
        end else if (d == DLY_JUMP) begin
            env_ptr = e[INDEX_W-1:0];
        end else if (d == DLY_RESTART) begin
            env_phase = PH_INITIAL;
        end else begin
            env_target = e[LEVEL_W-1:0];
            diff = {16'(env_target - env_level), 16'h0000};
            q = longint'(diff) / longint'(d);
            env_slope = q[FINE_W-1:0];
            env_phase = PH_FADE;
            env_ptr = env_ptr + 1'b1;
        end
    endfunction

    function automatic void env_tick();
        logic [REQ_W-1:0] act;
        bit run_start;
        bit run_loop;
        bit run_fade;
        act = env_pend;
        run_start = 1'b0;
        run_loop = 1'b0;
        run_fade = 1'b0;
        if (env_phase == PH_OFF)
            return;
        case (env_phase)
            PH_INITIAL: begin
                env_level = cfg_init;
                env_target = cfg_init;
                if (act[REQ_HANG])
                    env_phase = PH_HANG;
                else
                    run_start = 1'b1;
            end
            PH_START: run_start = 1'b1;
            PH_LOOP:  run_loop = 1'b1;
            PH_FADE:  run_fade = 1'b1;
            PH_DECAY, PH_RELEASE: begin
                env_level = env_level - cfg_rstep;
                if (cfg_sustain != 0 && env_phase == PH_DECAY) begin
                    if (env_level < $signed({1'b0, cfg_sustain})) begin
                        env_level = {1'b0, cfg_sustain};
                        env_ticks = 16'(cfg_sustain >> HOLD_SHIFT);
                        env_phase = PH_SUSTAIN;
                    end
                end else if (env_level < RELEASE_FLOOR) begin
                    env_level = '0;
                    env_phase = PH_OFF;
                end
            end
            PH_SUSTAIN: begin
                env_ticks = env_ticks - LEVEL_W'(1);
                if (env_ticks == 0)
                    env_phase = PH_RELEASE;
            end
            default: ;
        endcase
        if (run_start) begin
            env_ptr = '0;
            env_fine = {env_level, 16'h0000};
            env_phase = PH_LOOP;
            run_loop = 1'b1;
        end
        if (run_loop) begin
            open_entry();
            run_fade = (env_phase == PH_FADE);
        end
        if (run_fade) begin
            env_fine = env_fine + env_slope;
            env_level = env_fine[FINE_W-1:FRAC_W];
            env_ticks = env_ticks - LEVEL_W'(1);
            if (env_ticks <= 0)
                env_phase = PH_LOOP;
        end
        // release overrides decay and drops both requests
        if (act[REQ_DECAY]) begin
            env_phase = PH_DECAY;
            env_pend = act;
            env_pend[REQ_DECAY] = 1'b0;
        end
        if (act[REQ_RELEASE]) begin
            env_phase = PH_RELEASE;
            env_pend = act;
            env_pend[REQ_DECAY] = 1'b0;
            env_pend[REQ_RELEASE] = 1'b0;
        end
    endfunction

    function automatic t_env_result envelope_step(input t_env_word w);
        t_env_result r;
        case (w.action)
            ACT_TICK: begin
                if (w.req_hang)    env_pend[REQ_HANG] = 1'b1;
                if (w.req_decay)   env_pend[REQ_DECAY] = 1'b1;
                if (w.req_release) env_pend[REQ_RELEASE] = 1'b1;
                env_tick();
            end
            ACT_WRITE: env_tab[w.entry_index] = {w.entry_delay, w.entry_arg};
            ACT_START: begin
                env_phase = PH_INITIAL;
                env_pend = '0;
                env_ticks = '0;
                env_slope = '0;
            end
            default: ;
        endcase
        r.level = env_level;
        r.phase = (env_phase == PH_SUSTAIN) ? PHASE_W'(PH_RELEASE) : PHASE_W'(env_phase);
        r.in_sustain = (env_phase == PH_SUSTAIN);
        r.is_off = (env_phase == PH_OFF);
        return r;
    endfunction

    function automatic t_env_word noise_word();
        logic [63:0] bits;
        t_env_word   w;
        bits = {$urandom, $urandom};
        w = bits[$bits(t_env_word)-1:0];
        return w;
    endfunction

    function automatic t_env_word tick_word(input bit h, input bit d, input bit r);
        t_env_word w;
        w = noise_word();
        w.action = ACT_TICK;
        w.req_hang = h;
        w.req_decay = d;
        w.req_release = r;
        return w;
    endfunction

    function automatic t_env_word start_word();
        t_env_word w;
        w = noise_word();
        w.action = ACT_START;
        return w;
    endfunction

    function automatic t_env_word entry_word(input int idx, input int dly, input int arg);
        t_env_word w;
        w = noise_word();
        w.action = ACT_WRITE;
        w.entry_index = INDEX_W'(idx);
        w.entry_delay = LEVEL_W'(dly);
        w.entry_arg = LEVEL_W'(arg);
        return w;
    endfunction

    // mostly short ramps, a fair share of commands
    function automatic t_env_word random_entry();
        t_env_word w;
        w = noise_word();
        w.action = ACT_WRITE;
        case ($urandom_range(0, 19))
            0, 1: w.entry_delay = DLY_OFF;
            2:    w.entry_delay = DLY_HANG;
            3, 4: w.entry_delay = DLY_JUMP;
            5:    w.entry_delay = DLY_RESTART;
            6:    w.entry_delay = -16'($urandom_range(4, 32768));
            7, 8: ;
            default: w.entry_delay = 16'($urandom_range(1, 6));
        endcase
        return w;
    endfunction

    task automatic send_word(input t_env_word w);
        int unsigned gap;
        if ($urandom_range(0, 15) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            word_in.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        word_in.valid       <= 1'b1;
        word_in.action      <= w.action;
        word_in.entry_index <= w.entry_index;
        word_in.entry_delay <= w.entry_delay;
        word_in.entry_arg   <= w.entry_arg;
        word_in.req_hang    <= w.req_hang;
        word_in.req_decay   <= w.req_decay;
        word_in.req_release <= w.req_release;
        do @(posedge clk); while (!word_in.ready);
        levels_due.push_back(envelope_step(w));
        @(negedge clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle();
        word_in.valid <= 1'b0;
        while (levels_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_config(input logic [15:0] init_lvl, input logic [15:0] sus,
                              input logic [15:0] step);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_INITIAL_LEVEL;
        cfg_data <= init_lvl;
        @(negedge clk);
        cfg_idx  <= CFG_SUSTAIN_LEVEL;
        cfg_data <= sus;
        @(negedge clk);
        cfg_idx  <= CFG_RELEASE_STEP;
        cfg_data <= step;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_init = init_lvl;
        cfg_sustain = sus[SUSTAIN_W-1:0];
        cfg_rstep = step;
    endtask

    task automatic run_envelope(input int ticks, input int decay_at, input int release_at);
        int k;
        send_word(start_word());
        for (k = 0; k < ticks; k++)
            send_word(tick_word(1'b0, k == decay_at, k == release_at));
    endtask

    task automatic random_run(input int unsigned len);
        t_env_word   w;
        int unsigned k;
        send_word(start_word());
        run_words++;
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 19) == 0)
                w = noise_word();
            else
                w = tick_word(k == 0 ? $urandom_range(0, 2) == 0 : $urandom_range(0, 11) == 0,
                              $urandom_range(0, 11) == 0, $urandom_range(0, 19) == 0);
            send_word(w);
            if (w.action != ACT_NOP)
                run_words++;
        end
    endtask

    task automatic shuffle_config();
        logic [15:0] lvl;
        logic [15:0] sus;
        logic [15:0] step;
        case ($urandom_range(0, 4))
            0: lvl = 16'h8000;
            1: lvl = 16'h7FFF;
            2: lvl = 16'h0000;
            default: lvl = 16'($urandom);
        endcase
        case ($urandom_range(0, 6))
            0: sus = 16'h0000;
            1: sus = 16'($urandom_range(1, 15));
            2: sus = 16'h7FFF;
            3: sus = 16'($urandom_range(16, 100));
            default: sus = 16'($urandom_range(16, 4000));
        endcase
        sus[15] = 1'($urandom);
        case ($urandom_range(0, 5))
            0: step = 16'h8000;
            1: step = 16'h7FFF;
            2: step = 16'h0001;
            3: step = 16'h0000;
            default: step = 16'($urandom_range(50, 6000));
        endcase
        set_config(lvl, sus, step);
    endtask

    // every entry gets written, with a program that holds each command
    task automatic test_table_fill();
        int dly [TABLE_DEPTH] = '{2, 1, -5, -2, 0, -32768, -2, 0,
                                  2, -1, 0, -3, 1, -2, 32767, 1};
        int arg [TABLE_DEPTH] = '{32767, -32768, 1000, 5, 0, 0, 'hFFFC, 0,
                                  100, 0, 0, 0, 0, 14, 100, 50};
        int i;
        for (i = 0; i < TABLE_DEPTH; i++)
            send_word(entry_word(i, dly[i], arg[i]));
    endtask

    task automatic test_table_walk();
        set_config(16'd5000, 16'd0, 16'd8000);
        run_envelope(12, 9, 11);
    endtask

    task automatic test_hang_and_requests();
        t_env_word w;
        send_word(start_word());
        send_word(tick_word(1'b1, 1'b0, 1'b0));
        send_word(tick_word(1'b0, 1'b0, 1'b0));
        send_word(tick_word(1'b0, 1'b1, 1'b1));
        send_word(tick_word(1'b0, 1'b0, 1'b0));
        // disabled by now: the decay request must stay pending
        send_word(tick_word(1'b0, 1'b1, 1'b0));
        w = noise_word();
        w.action = ACT_NOP;
        send_word(w);
        send_word(start_word());
        send_word(tick_word(1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_config_extremes();
        set_config(16'h7FFF, 16'h0000, 16'h8000);
        run_envelope(4, 0, 99);
        set_config(16'h8000, 16'h7FFF, 16'h7FFF);
        run_envelope(4, 1, 99);
        // sustain under 16: hold count of zero wraps around
        set_config(16'h0000, 16'd15, 16'd20000);
        run_envelope(5, 0, 3);
        set_config(16'd12345, 16'hFFFF, 16'h0001);
        run_envelope(4, 0, 2);
    endtask

    task automatic test_output_stall();
        hold_off_req = 1'b1;
        random_run(40);
    endtask

    task automatic test_random_programs(input int unsigned n_words);
        int unsigned episodes;
        episodes = 0;
        run_words = 0;
        while (run_words < n_words) begin
            if (episodes % 6 == 5)
                shuffle_config();
            repeat ($urandom_range(0, 3)) begin
                send_word(random_entry());
                run_words++;
            end
            random_run($urandom_range(4, 40));
            episodes++;
        end
    endtask

    initial begin : stimulus
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_INITIAL_LEVEL;
        cfg_data = '0;
        word_in.valid = 1'b0;
        word_in.action = ACT_NOP;
        word_in.entry_index = '0;
        word_in.entry_delay = '0;
        word_in.entry_arg = '0;
        word_in.req_hang = 1'b0;
        word_in.req_decay = 1'b0;
        word_in.req_release = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_table_fill();
        test_table_walk();
        test_hang_and_requests();
        test_config_extremes();
        test_output_stall();
        test_random_programs(940);

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin : result_taker
        int unsigned stall;
        bit calm;
        calm = 1'b0;
        word_out.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_off_req) begin
                word_out.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            if ($urandom_range(0, 15) == 0)
                calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                word_out.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            word_out.ready <= 1'b1;
            do @(posedge clk); while (!word_out.valid);
            @(negedge clk);
        end
    end

    task automatic report_field(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    endtask

    always @(posedge clk) begin : check_results
        t_env_result want;
        if (rst_n && word_out.valid && word_out.ready) begin
            if (levels_due.size() == 0) begin
                mismatches++;
                $display("%0t: result word with none expected, level %0d phase %0d",
                         $time, word_out.level, word_out.phase);
            end else begin
                want = levels_due.pop_front();
                if (word_out.level !== want.level)
                    report_field("level", want.level, word_out.level);
                if (word_out.phase !== want.phase)
                    report_field("phase", want.phase, word_out.phase);
                if (word_out.in_sustain !== want.in_sustain)
                    report_field("in_sustain", want.in_sustain, word_out.in_sustain);
                if (word_out.is_off !== want.is_off)
                    report_field("is_off", want.is_off, word_out.is_off);
            end
        end
    end

    initial begin : watchdog
        #1_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
